// File: src/effa_pkg.sv
// shared types and constants for the extent first-fit allocator
// no dependencies; imported by every module of the block but effa_ram
`default_nettype none

package effa_pkg;

   localparam int START_W = 36;
   localparam int LEN_W   = 37;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_IGNORED = 2'd1,
      ST_NOSPACE = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef struct packed {
      alu_op_type         op;
      logic [LEN_W-1:0]   a;
      logic [LEN_W-1:0]   b;
   } alu_req_type;

   typedef struct packed {
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   len;
   } entry_type;

   typedef enum logic [4:0] {
      S_INIT,
      S_IDLE,
      S_A_RD,
      S_A_CHK,
      S_A_CUT,
      S_RM_RD,
      S_RM_WR,
      S_F_RD,
      S_F_CHK,
      S_F_LEFT,
      S_F_LMRG,
      S_F_LCHK,
      S_F_LADD,
      S_F_RIGHT,
      S_F_RMRG,
      S_SH_RD,
      S_SH_WR,
      S_RESP
   } state_type;

endpackage

`default_nettype wire

// File: src/extent_first_fit_allocator.sv
// top level of the extent first-fit allocator: sequencer, extent table, shared alu
// depends on effa_pkg, effa_ram, effa_alu
`default_nettype none

// Keeps a sorted table of free page extents in one ram and serves one command
// at a time. An allocate walks the table from the front and takes the first
// extent long enough, cutting from its front or removing it when the length
// matches; a free walks to the insert point, then merges with a touching
// neighbor on either side or opens a new entry. Every table step goes through
// the single ram port pair and the single shared adder: an allocate reads
// and checks each entry from the front and shifts the entries above down
// on a removal, a free reads up to its place and shifts the entries above
// up on an insert or down when it joins both neighbors. After reset or any
// register write the table is rebuilt as one extent at the pool base in the
// S_INIT state. A zero count, or a free of page 0, answers "ignored". The
// result sits in an output register, so the next item is taken while it
// waits.
module extent_first_fit_allocator #(
   parameter int MAX_EXTENTS = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // command stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // page_count[35:0], first freed page[71:36]
   input  wire logic        req_tuser,   // command
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // alloc_page[35:0], zero pad
   output logic [1:0]       rsp_tuser,   // status
   // register writes
   input  wire logic        csr_we,
   input  wire logic        csr_index,   // 0 base page, 1 page count of the pool
   input  wire logic [35:0] csr_wdata
);
   import effa_pkg::*;

   localparam int AW = $clog2(MAX_EXTENTS);
   localparam int CW = $clog2(MAX_EXTENTS + 1);

   state_type            state_ff, state_in;
   logic [START_W-1:0]   base_ff;
   logic [START_W-1:0]   pages_ff;
   logic [CW-1:0]        used_ff, used_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        j_ff, j_in;
   logic [START_W-1:0]   cnt_ff, sp_ff;
   entry_type            prev_ff, prev_in;
   entry_type            cur_ff, cur_in;
   logic [LEN_W-1:0]     acc_ff, acc_in;
   status_type           status_ff, status_in;
   logic [START_W-1:0]   page_ff, page_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff;
   logic [START_W-1:0]   rsp_page_ff;

   // ram and alu hookups
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr, ram_raddr;
   entry_type            ram_wdata, ram_rdata;
   alu_req_type          alu_req;
   logic [LEN_W:0]       alu_res;

   // conditions on the shared unit output
   logic                 borrow, res_zero, idx_in_table, res_hits_cur;
   logic                 resp_load, req_fire;
   logic [CW-1:0]        idx_m1, j_m1;

   assign borrow       = alu_res[LEN_W];
   assign res_zero     = (alu_res == '0);
   assign idx_in_table = (idx_ff != used_ff);
   assign res_hits_cur = (alu_res == {2'b00, cur_ff.start});
   assign idx_m1       = idx_ff - CW'(1);
   assign j_m1         = j_ff - CW'(1);
   assign req_fire     = req_tvalid && req_tready;
   assign resp_load    = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_tready);

   effa_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_EXTENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   effa_alu u_alu (
      .req (alu_req),
      .res (alu_res)
   );

   // operand selection for the shared adder, one operation per state
   always_comb begin
      alu_req = '{op: ALU_ADD, a: '0, b: '0};
      unique case (state_ff)
         S_A_CHK:   alu_req = '{op: ALU_SUB, a: ram_rdata.len, b: {1'b0, cnt_ff}};
         S_A_CUT:   alu_req = '{op: ALU_ADD, a: {1'b0, cur_ff.start}, b: {1'b0, cnt_ff}};
         S_F_CHK:   alu_req = '{op: ALU_SUB, a: {1'b0, ram_rdata.start}, b: {1'b0, sp_ff}};
         S_F_LEFT:  alu_req = '{op: ALU_ADD, a: {1'b0, prev_ff.start}, b: prev_ff.len};
         S_F_LMRG:  alu_req = '{op: ALU_ADD, a: prev_ff.len, b: {1'b0, cnt_ff}};
         S_F_LCHK:  alu_req = '{op: ALU_ADD, a: {1'b0, prev_ff.start}, b: acc_ff};
         S_F_LADD:  alu_req = '{op: ALU_ADD, a: acc_ff, b: cur_ff.len};
         S_F_RIGHT: alu_req = '{op: ALU_ADD, a: {1'b0, sp_ff}, b: {1'b0, cnt_ff}};
         S_F_RMRG:  alu_req = '{op: ALU_ADD, a: {1'b0, cnt_ff}, b: cur_ff.len};
         default:   alu_req = '{op: ALU_ADD, a: '0, b: '0};
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: state_in = S_IDLE;
         S_IDLE: begin
            if (req_fire) begin
               if (req_tdata[35:0] == '0 || (req_tuser == CMD_FREE && req_tdata[71:36] == '0))
                  state_in = S_RESP;
               else if (req_tuser == CMD_ALLOC)
                  state_in = S_A_RD;
               else
                  state_in = S_F_RD;
            end
         end
         S_A_RD:    state_in = idx_in_table ? S_A_CHK : S_RESP;
         S_A_CHK: begin
            if (borrow)        state_in = S_A_RD;
            else if (res_zero) state_in = S_RM_RD;
            else               state_in = S_A_CUT;
         end
         S_A_CUT:   state_in = S_RESP;
         S_RM_RD:   state_in = (j_ff == used_ff) ? S_RESP : S_RM_WR;
         S_RM_WR:   state_in = S_RM_RD;
         S_F_RD:    state_in = idx_in_table ? S_F_CHK : S_F_LEFT;
         S_F_CHK:   state_in = borrow ? S_F_RD : S_F_LEFT;
         S_F_LEFT: begin
            if (idx_ff != '0 && alu_res == {2'b00, sp_ff}) state_in = S_F_LMRG;
            else if (used_ff == CW'(MAX_EXTENTS))          state_in = S_RESP;
            else                                           state_in = S_F_RIGHT;
         end
         S_F_LMRG:  state_in = S_F_LCHK;
         S_F_LCHK:  state_in = (idx_in_table && res_hits_cur) ? S_F_LADD : S_RESP;
         S_F_LADD:  state_in = S_RM_RD;
         S_F_RIGHT: state_in = (idx_in_table && res_hits_cur) ? S_F_RMRG : S_SH_RD;
         S_F_RMRG:  state_in = S_RESP;
         S_SH_RD:   state_in = (j_ff == idx_ff) ? S_RESP : S_SH_WR;
         S_SH_WR:   state_in = S_SH_RD;
         S_RESP:    state_in = resp_load ? S_IDLE : S_RESP;
         default:   state_in = S_INIT;
      endcase
      // a register write rebuilds the table
      if (csr_we) state_in = S_INIT;
   end

   // datapath and table access per state
   always_comb begin
      used_in   = used_ff;
      idx_in    = idx_ff;
      j_in      = j_ff;
      prev_in   = prev_ff;
      cur_in    = cur_ff;
      acc_in    = acc_ff;
      status_in = status_ff;
      page_in   = page_ff;
      ram_we    = 1'b0;
      ram_waddr = idx_ff[AW-1:0];
      ram_wdata = '{start: sp_ff, len: {1'b0, cnt_ff}};
      ram_raddr = idx_ff[AW-1:0];
      unique case (state_ff)
         S_INIT: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = '{start: base_ff, len: {1'b0, pages_ff}};
            used_in   = CW'(1);
         end
         S_IDLE: begin
            idx_in    = '0;
            page_in   = '0;
            status_in = ST_IGNORED;
         end
         S_A_RD: begin
            if (!idx_in_table) status_in = ST_NOSPACE;
         end
         S_A_CHK: begin
            cur_in = ram_rdata;
            acc_in = alu_res[LEN_W-1:0];
            if (!borrow) begin
               page_in   = ram_rdata.start;
               status_in = ST_DONE;
               j_in      = idx_ff + CW'(1);
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         S_A_CUT: begin
            ram_we    = 1'b1;
            ram_wdata = '{start: alu_res[START_W-1:0], len: acc_ff};
         end
         // pull entries above the removed one down by one place
         S_RM_RD: begin
            ram_raddr = j_ff[AW-1:0];
            if (j_ff == used_ff) used_in = used_ff - CW'(1);
         end
         S_RM_WR: begin
            ram_we    = 1'b1;
            ram_waddr = j_m1[AW-1:0];
            ram_wdata = ram_rdata;
            j_in      = j_ff + CW'(1);
         end
         S_F_CHK: begin
            if (borrow) begin
               prev_in = ram_rdata;
               idx_in  = idx_ff + CW'(1);
            end else begin
               cur_in = ram_rdata;
            end
         end
         S_F_LEFT: begin
            if (!(idx_ff != '0 && alu_res == {2'b00, sp_ff}) && used_ff == CW'(MAX_EXTENTS))
               status_in = ST_FULL;
         end
         S_F_LMRG: acc_in = alu_res[LEN_W-1:0];
         S_F_LCHK: begin
            status_in = ST_DONE;
            if (!(idx_in_table && res_hits_cur)) begin
               ram_we    = 1'b1;
               ram_waddr = idx_m1[AW-1:0];
               ram_wdata = '{start: prev_ff.start, len: acc_ff};
            end
         end
         S_F_LADD: begin
            ram_we    = 1'b1;
            ram_waddr = idx_m1[AW-1:0];
            ram_wdata = '{start: prev_ff.start, len: alu_res[LEN_W-1:0]};
            j_in      = idx_ff + CW'(1);
         end
         S_F_RIGHT: begin
            status_in = ST_DONE;
            j_in      = used_ff;
         end
         S_F_RMRG: begin
            ram_we    = 1'b1;
            ram_wdata = '{start: sp_ff, len: alu_res[LEN_W-1:0]};
         end
         // open a hole at the insert point, top entry first
         S_SH_RD: begin
            ram_raddr = j_m1[AW-1:0];
            if (j_ff == idx_ff) begin
               ram_we  = 1'b1;
               used_in = used_ff + CW'(1);
            end
         end
         S_SH_WR: begin
            ram_we    = 1'b1;
            ram_waddr = j_ff[AW-1:0];
            ram_wdata = ram_rdata;
            j_in      = j_m1;
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = resp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         base_ff      <= START_W'(512);
         pages_ff     <= START_W'(65536);
         used_ff      <= CW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == 1'b0) base_ff  <= csr_wdata;
         if (csr_we && csr_index == 1'b1) pages_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      j_ff      <= j_in;
      prev_ff   <= prev_in;
      cur_ff    <= cur_in;
      acc_ff    <= acc_in;
      status_ff <= status_in;
      page_ff   <= page_in;
      if (req_fire) begin
         cnt_ff <= req_tdata[35:0];
         sp_ff  <= req_tdata[71:36];
      end
      if (resp_load) begin
         rsp_status_ff <= status_ff;
         rsp_page_ff   <= page_ff;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {4'b0000, rsp_page_ff};

endmodule

`default_nettype wire

// File: src/effa_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module effa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: src/effa_alu.sv
// shared 37-bit add/subtract unit used by the check, cut and merge steps of the sequencer
// depends on effa_pkg
`default_nettype none

module effa_alu (
   input  wire effa_pkg::alu_req_type          req,
   output logic [effa_pkg::LEN_W:0]            res
);
   import effa_pkg::*;

   always_comb begin
      unique case (req.op)
         ALU_ADD: res = {1'b0, req.a} + {1'b0, req.b};
         ALU_SUB: res = {1'b0, req.a} - {1'b0, req.b};
         default: res = '0;
      endcase
   end

endmodule

`default_nettype wire

// File: src/effa_checker.sv
// port-level checks for the extent first-fit allocator, bound to the top level
// depends on effa_pkg and extent_first_fit_allocator
`default_nettype none

module effa_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);
   import effa_pkg::*;

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // only a completed allocate carries a page
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_DONE |-> rsp_tdata == '0)
      else $error("page on a failed or ignored item");

   // one item at a time: no accept right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while busy");

   // a new result is loaded only from a busy cycle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result raised while idle");

endmodule

bind extent_first_fit_allocator effa_checker u_effa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// File: sim/testbench.sv
// self-checking bench for the extent first-fit allocator: random and directed commands
// depends on effa_pkg and extent_first_fit_allocator
`default_nettype none

module testbench;
   import effa_pkg::*;

   localparam int NUM_EXT = 256;
   localparam int N_RANDOM = 750;

   typedef struct packed {
      cmd_type     command;
      logic [35:0] page_count;
      logic [35:0] free_page;
   } cmd_item_type;

   typedef struct packed {
      status_type  status;
      logic [35:0] alloc_page;
   } rsp_item_type;

   logic clock;
   logic reset;
   logic req_tvalid, req_tready;
   logic [71:0] req_tdata;
   logic req_tuser;
   logic rsp_tvalid, rsp_tready;
   logic [39:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_we;
   logic csr_index;
   logic [35:0] csr_wdata;

   extent_first_fit_allocator #(.MAX_EXTENTS(NUM_EXT)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow of the free extent table
   logic [35:0] cfg_base, pool_size;
   logic [35:0] ext_start [NUM_EXT];
   logic [36:0] ext_len [NUM_EXT];
   int          ext_used;

   cmd_item_type pending_cmds [$];
   rsp_item_type expected_rsps [$];
   int        errors = 0;
   bit        quiet_tail = 0;   // no idling in the last part of the run
   bit        hold_sender = 0;  // pauses the driver between phases
   int        rsp_holdoff = 0;  // long receiver stall, in cycles

   // free-extent list helpers
   function automatic void rebuild_table();
      for (int k = 0; k < NUM_EXT; k++) begin
         ext_start[k] = '0;
         ext_len[k] = '0;
      end
      ext_start[0] = cfg_base;
      ext_len[0] = {1'b0, pool_size};
      ext_used = 1;
   endfunction

   function automatic void drop_extent(int idx);
      for (int k = idx; k < ext_used - 1; k++) begin
         ext_start[k] = ext_start[k+1];
         ext_len[k] = ext_len[k+1];
      end
      ext_used--;
      ext_start[ext_used] = '0;
      ext_len[ext_used] = '0;
   endfunction

   // works out the answer to one command and updates the shadow table
   function automatic rsp_item_type allocate_or_free(cmd_item_type c);
      rsp_item_type r;
      int idx;
      logic [37:0] edge_sum;
      r.status = ST_IGNORED;
      r.alloc_page = '0;
      if (c.command == CMD_ALLOC) begin
         if (c.page_count != 0) begin
            r.status = ST_NOSPACE;
            for (idx = 0; idx < ext_used; idx++) begin
               if (ext_len[idx] >= {1'b0, c.page_count}) begin
                  r.alloc_page = ext_start[idx];
                  if (ext_len[idx] == {1'b0, c.page_count}) drop_extent(idx);
                  else begin
                     ext_start[idx] = ext_start[idx] + c.page_count;
                     ext_len[idx] = ext_len[idx] - {1'b0, c.page_count};
                  end
                  r.status = ST_DONE;
                  break;
               end
            end
         end
      end else if (c.page_count != 0 && c.free_page != 0) begin
         idx = 0;
         while (idx < ext_used && ext_start[idx] < c.free_page) idx++;
         edge_sum = (idx > 0) ? ext_start[idx-1] + ext_len[idx-1] : '0;
         if (idx > 0 && edge_sum == {2'b0, c.free_page}) begin
            // left neighbor touches: grow it, then maybe swallow the right one
            ext_len[idx-1] = ext_len[idx-1] + c.page_count;
            if (idx < ext_used &&
                38'(ext_start[idx-1]) + 38'(ext_len[idx-1]) == 38'(ext_start[idx])) begin
               ext_len[idx-1] = ext_len[idx-1] + ext_len[idx];
               drop_extent(idx);
            end
            r.status = ST_DONE;
         end else if (ext_used >= NUM_EXT) begin
            r.status = ST_FULL;
         end else begin
            for (int k = ext_used; k > idx; k--) begin
               ext_start[k] = ext_start[k-1];
               ext_len[k] = ext_len[k-1];
            end
            ext_start[idx] = c.free_page;
            ext_len[idx] = {1'b0, c.page_count};
            ext_used++;
            if (idx + 1 < ext_used &&
                38'(c.free_page) + 38'(c.page_count) == 38'(ext_start[idx+1])) begin
               ext_len[idx] = {1'b0, c.page_count} + ext_len[idx+1];
               drop_extent(idx + 1);
            end
            r.status = ST_DONE;
         end
      end
      return r;
   endfunction

   function automatic cmd_item_type make_cmd(cmd_type op, logic [35:0] cnt, logic [35:0] sp);
      cmd_item_type c;
      c.command = op;
      c.page_count = cnt;
      c.free_page = sp;
      return c;
   endfunction

   function automatic logic [35:0] rand36();
      return {4'($urandom_range(15, 0)), $urandom()};
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // driver: offers queued items, idles in random bursts
   int drv_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_rsps.push_back(allocate_or_free(pending_cmds.pop_front()));
         end
         if (req_tvalid && !req_tready) begin
            // hold the item until taken
         end else if (drv_gap > 0) begin
            drv_gap <= drv_gap - 1;
            req_tvalid <= 1'b0;
         end else if (!quiet_tail && $urandom_range(9, 0) == 0) begin
            drv_gap <= $urandom_range(10, 1);
            req_tvalid <= 1'b0;
         end else if (pending_cmds.size() > 0 && !hold_sender) begin
            req_tvalid <= 1'b1;
            req_tuser <= pending_cmds[0].command;
            req_tdata <= {pending_cmds[0].free_page, pending_cmds[0].page_count};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: stalls in random bursts and checks each result
   int mon_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result: status %0d alloc_page %0h", rsp_tuser, rsp_tdata[35:0]);
               errors++;
            end else begin
               rsp_item_type e;
               e = expected_rsps.pop_front();
               if (rsp_tuser !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_tuser);
                  errors++;
               end
               if (rsp_tdata !== {4'b0, e.alloc_page}) begin
                  $error("alloc_page: expected %0h, got %0h", e.alloc_page, rsp_tdata);
                  errors++;
               end
            end
         end
         if (rsp_holdoff > 0) begin
            rsp_holdoff <= rsp_holdoff - 1;
            rsp_tready <= 1'b0;
         end else if (mon_gap > 0) begin
            mon_gap <= mon_gap - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(9, 0) == 0) begin
            mon_gap <= $urandom_range(10, 1);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic wait_drained();
      while (pending_cmds.size() != 0 || expected_rsps.size() != 0) @(posedge clock);
      // a command still inside the block cannot exist once all answers are back,
      // but leave a short settle margin before any register write
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [35:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == 1'b0) cfg_base = val;
      else pool_size = val;
      rebuild_table();
   endtask

   // mixed traffic: allocations, frees of random small holes, and ignored or random commands
   task automatic random_phase(int n, int max_cnt);
      cmd_item_type c;
      int pick;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(99, 0);
         if (pick < 45) begin
            c = make_cmd(CMD_ALLOC, 36'($urandom_range(max_cnt, 1)), '0);
            c.free_page = rand36();   // unused field, random content
            pending_cmds.push_back(c);
         end else if (pick < 85) begin
            // free a random small hole inside a plausible page range
            c = make_cmd(CMD_FREE, 36'($urandom_range(max_cnt, 1)),
                         cfg_base + 36'($urandom_range(4 * max_cnt * 40, 1)));
            pending_cmds.push_back(c);
         end else if (pick < 92) begin
            pending_cmds.push_back(make_cmd(cmd_type'($urandom_range(1, 0)), '0, rand36()));
         end else if (pick < 96) begin
            pending_cmds.push_back(make_cmd(CMD_FREE, rand36(), '0));
         end else begin
            pending_cmds.push_back(make_cmd(cmd_type'($urandom_range(1, 0)), rand36(), rand36()));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = 1'b0;
      csr_wdata = '0;
      cfg_base = 36'd512;
      pool_size = 36'd65536;
      rebuild_table();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, both commands, ignored, no-space and merge cases
      pending_cmds.push_back(make_cmd(CMD_ALLOC, '0, '0));
      pending_cmds.push_back(make_cmd(CMD_FREE, '0, 36'd100));
      pending_cmds.push_back(make_cmd(CMD_FREE, 36'd5, '0));
      pending_cmds.push_back(make_cmd(CMD_ALLOC, 36'd1, '1));
      pending_cmds.push_back(make_cmd(CMD_ALLOC, 36'd100, '0));
      pending_cmds.push_back(make_cmd(CMD_ALLOC, '1, '0));
      pending_cmds.push_back(make_cmd(CMD_FREE, 36'd1, 36'd512));
      pending_cmds.push_back(make_cmd(CMD_FREE, 36'd50, 36'd513));
      pending_cmds.push_back(make_cmd(CMD_FREE, 36'd10, 36'd10));
      pending_cmds.push_back(make_cmd(CMD_FREE, 36'd10, 36'd30));
      pending_cmds.push_back(make_cmd(CMD_FREE, 36'd10, 36'd20));
      pending_cmds.push_back(make_cmd(CMD_ALLOC, 36'd30, '0));
      pending_cmds.push_back(make_cmd(CMD_FREE, '1, '1));
      pending_cmds.push_back(make_cmd(CMD_ALLOC, 36'd65435, '0));
      pending_cmds.push_back(make_cmd(CMD_ALLOC, 36'd1, '0));
      wait_drained();

      // tiny pool at the top of the page space, start wraps on a front cut
      write_reg(1'b0, '1);
      write_reg(1'b1, 36'd4);
      pending_cmds.push_back(make_cmd(CMD_ALLOC, 36'd2, '0));
      pending_cmds.push_back(make_cmd(CMD_ALLOC, 36'd2, '0));
      pending_cmds.push_back(make_cmd(CMD_FREE, '1, 36'h800000000));
      pending_cmds.push_back(make_cmd(CMD_FREE, '1, '1));
      wait_drained();

      // empty pool: nothing can be taken
      write_reg(1'b0, 36'd1);
      write_reg(1'b1, '0);
      pending_cmds.push_back(make_cmd(CMD_ALLOC, 36'd1, '0));
      wait_drained();

      // fill the table with disjoint frees to reach the full case; the receiver
      // stalls meanwhile so the block backs up its input
      write_reg(1'b0, 36'd2);
      write_reg(1'b1, 36'd1);
      rsp_holdoff = 3000;
      for (int k = 0; k < NUM_EXT + 4; k++)
         pending_cmds.push_back(make_cmd(CMD_FREE, 36'd1, 36'(10 + 3 * k)));
      wait_drained();

      // random phases over several register settings
      write_reg(1'b0, 36'd512);
      write_reg(1'b1, 36'd4096);
      random_phase(N_RANDOM / 3, 64);
      hold_sender = 1;
      while (expected_rsps.size() != 0 || req_tvalid) @(posedge clock);
      hold_sender = 0;
      wait_drained();

      write_reg(1'b1, '1);
      write_reg(1'b0, 36'($urandom_range(1000, 1)));
      random_phase(N_RANDOM / 3, 200);
      wait_drained();

      write_reg(1'b0, 36'd512);
      write_reg(1'b1, 36'd65536);
      quiet_tail = 1;
      random_phase(N_RANDOM / 3, 32);
      wait_drained();
      repeat (1200) @(posedge clock);

      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #30000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
